[hw/rtl/hta_pkg.sv]
// Shared types and constants for the Heron triangle area pipeline.
// Used by every module of the block; depends on nothing else.
package hta_pkg;

    localparam int SIDE_BITS = 12;
    localparam int AREA_BITS = 25;

    // The perimeter needs two extra bits; a valid factor such as b+c-a needs one.
    localparam int SUM_W  = SIDE_BITS + 2;
    localparam int FAC_W  = SIDE_BITS + 1;
    localparam int M1_W   = SUM_W + FAC_W;
    localparam int M2_W   = 2 * FAC_W;
    localparam int PROD_W = M1_W + M2_W;

    // Square root: SQ_PER result bits per stage, radicand padded to a whole stage count.
    localparam int RT_W      = (PROD_W + 1) / 2;
    localparam int SQ_PER    = 2;
    localparam int SQ_STAGES = (RT_W + SQ_PER - 1) / SQ_PER;
    localparam int RT_PAD    = SQ_PER * SQ_STAGES;
    localparam int RAD_W     = 2 * RT_PAD;
    localparam int RM_W      = RT_PAD + 2;

    typedef struct packed {
        logic [SIDE_BITS-1:0] side_a;
        logic [SIDE_BITS-1:0] side_b;
        logic [SIDE_BITS-1:0] side_c;
    } t_in;

    typedef struct packed {
        logic [AREA_BITS-1:0] area_quarters;
        logic                 invalid;
    } t_out;

endpackage

[hw/rtl/heron_triangle_area.sv]
// Top level of the Heron triangle area pipeline: front end, square root, output stage.
// Depends on hta_pkg, hta_front and hta_sqrt.
//
// Usage: each input beat on i_valid/o_stall carries three unsigned sides; each
// output beat on o_valid/i_stall carries floor(4 * area) and an invalid flag.
// A zero side or a broken triangle inequality gives invalid = 1 and area 0; a
// degenerate triangle gives area 0 with invalid = 0.
//
// Throughput is one triangle per cycle while the receiver does not stall. The pipeline
// has one stage for the perimeter and factors, two multiplier stages, one square-root stage
// per two result bits (14 stages), and the output register that also saturates.
//
// Reset (i_rst_n low at a clock edge) empties every stage; nothing is buffered
// afterwards. When the receiver stalls, the output beat holds, and the stages
// behind it keep taking items until every stage is full; only then does o_stall
// rise. Each stage's valid bit travels with its data, so no beat is lost or repeated.
module heron_triangle_area (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hta_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output hta_pkg::t_out o_out
);
    import hta_pkg::*;

    logic              front_ready, front_valid, front_bad;
    logic [PROD_W-1:0] front_prod;
    logic              sq_ready, sq_valid, sq_bad;
    logic [RT_PAD-1:0] sq_root;
    logic              out_ready;
    logic              r_out_v;
    t_out              r_out;
    t_out              n_out;

    hta_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sides (i_in),
        .i_ready (sq_ready),
        .o_ready (front_ready),
        .o_valid (front_valid),
        .o_prod  (front_prod),
        .o_bad   (front_bad)
    );

    hta_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_prod  (front_prod),
        .i_bad   (front_bad),
        .i_ready (out_ready),
        .o_ready (sq_ready),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_bad   (sq_bad)
    );

    assign out_ready = !r_out_v || !i_stall;
    assign o_stall   = !front_ready;

    always_comb begin
        if (sq_root[RT_PAD-1:AREA_BITS] != '0) begin
            n_out.area_quarters = '1;
        end else begin
            n_out.area_quarters = sq_root[AREA_BITS-1:0];
        end
        n_out.invalid = sq_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

endmodule

[hw/rtl/hta_front.sv]
// Front end: perimeter, the three difference factors, and the 16*area^2 product.
// Three register stages with two multiplier levels; depends on hta_pkg.
module hta_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  hta_pkg::t_in                i_sides,
    input  logic                        i_ready,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [hta_pkg::PROD_W-1:0]  o_prod,
    output logic                        o_bad
);
    import hta_pkg::*;

    logic [SUM_W-1:0] a_x, b_x, c_x;
    logic [SUM_W-1:0] sum, da, db, dc;
    logic             bad;

    logic             r_v1, r_v2, r_v3;
    logic             rdy1, rdy2, rdy3;
    logic [SUM_W-1:0] r_sum1;
    logic [FAC_W-1:0] r_fa1, r_fb1, r_fc1;
    logic             r_bad1;
    logic [M1_W-1:0]  r_m1;
    logic [M2_W-1:0]  r_m2;
    logic             r_bad2;
    logic [PROD_W-1:0] r_prod;
    logic             r_bad3;

    // A stage moves when it is empty or the stage after it moves.
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        a_x = {2'b00, i_sides.side_a};
        b_x = {2'b00, i_sides.side_b};
        c_x = {2'b00, i_sides.side_c};
        sum = a_x + b_x + c_x;
        // A negative difference wraps high enough to set the top bit.
        da  = b_x + c_x - a_x;
        db  = a_x + c_x - b_x;
        dc  = a_x + b_x - c_x;
        bad = (i_sides.side_a == '0) || (i_sides.side_b == '0) ||
              (i_sides.side_c == '0) || da[SUM_W-1] || db[SUM_W-1] || dc[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_sum1 <= sum;
            // Zeroing one factor of a bad triangle forces a zero product and root.
            r_fa1  <= bad ? '0 : da[FAC_W-1:0];
            r_fb1  <= db[FAC_W-1:0];
            r_fc1  <= dc[FAC_W-1:0];
            r_bad1 <= bad;
        end
        if (rdy2) begin
            r_m1   <= M1_W'(r_sum1) * M1_W'(r_fa1);
            r_m2   <= M2_W'(r_fb1) * M2_W'(r_fc1);
            r_bad2 <= r_bad1;
        end
        if (rdy3) begin
            r_prod <= PROD_W'(r_m1) * PROD_W'(r_m2);
            r_bad3 <= r_bad2;
        end
    end

    assign o_valid = r_v3;
    assign o_prod  = r_prod;
    assign o_bad   = r_bad3;

endmodule

[hw/rtl/hta_sqrt.sv]
// Pipelined floor square root, SQ_PER result bits per register stage.
// Restoring digit-by-digit method; depends on hta_pkg.
module hta_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [hta_pkg::PROD_W-1:0]  i_prod,
    input  logic                        i_bad,
    input  logic                        i_ready,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [hta_pkg::RT_PAD-1:0]  o_root,
    output logic                        o_bad
);
    import hta_pkg::*;

    logic              r_v   [SQ_STAGES];
    logic [RM_W-1:0]   r_rem [SQ_STAGES];
    logic [RT_PAD-1:0] r_q   [SQ_STAGES];
    logic [RAD_W-1:0]  r_rad [SQ_STAGES];
    logic              r_bad [SQ_STAGES];

    logic              s_v   [SQ_STAGES];
    logic [RM_W-1:0]   s_rem [SQ_STAGES];
    logic [RT_PAD-1:0] s_q   [SQ_STAGES];
    logic [RAD_W-1:0]  s_rad [SQ_STAGES];
    logic              s_bad [SQ_STAGES];

    logic [RM_W-1:0]   n_rem [SQ_STAGES];
    logic [RT_PAD-1:0] n_q   [SQ_STAGES];
    logic [RAD_W-1:0]  n_rad [SQ_STAGES];

    logic              rdy   [SQ_STAGES+1];

    assign rdy[SQ_STAGES] = i_ready;
    assign o_ready        = rdy[0];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign s_v[k]   = i_valid;
            assign s_rem[k] = '0;
            assign s_q[k]   = '0;
            assign s_rad[k] = RAD_W'(i_prod);
            assign s_bad[k] = i_bad;
        end else begin : g_next
            assign s_v[k]   = r_v[k-1];
            assign s_rem[k] = r_rem[k-1];
            assign s_q[k]   = r_q[k-1];
            assign s_rad[k] = r_rad[k-1];
            assign s_bad[k] = r_bad[k-1];
        end

        assign rdy[k] = !r_v[k] || rdy[k+1];

        always_comb begin
            logic [RM_W-1:0]   rem;
            logic [RT_PAD-1:0] q;
            logic [RM_W+1:0]   sh;
            logic [RM_W+1:0]   cand;
            logic [RM_W+1:0]   diff;
            rem = s_rem[k];
            q   = s_q[k];
            for (int j = 0; j < SQ_PER; j++) begin
                // Bring down the next two radicand bits and try root digit one.
                sh   = {rem, s_rad[k][RAD_W-1-2*j -: 2]};
                cand = {{(RM_W-RT_PAD){1'b0}}, q, 2'b01};
                diff = sh - cand;
                if (sh >= cand) begin
                    rem = diff[RM_W-1:0];
                    q   = {q[RT_PAD-2:0], 1'b1};
                end else begin
                    rem = sh[RM_W-1:0];
                    q   = {q[RT_PAD-2:0], 1'b0};
                end
            end
            n_rem[k] = rem;
            n_q[k]   = q;
            n_rad[k] = s_rad[k] << (2 * SQ_PER);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_rad[k] <= n_rad[k];
                r_bad[k] <= s_bad[k];
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_q[SQ_STAGES-1];
    assign o_bad   = r_bad[SQ_STAGES-1];

endmodule
